[hdl/msst_pkg.sv]
package msst_pkg;

	localparam int DEF_SLOTS      = 32;
	localparam int DEF_COUNT_BITS = 16;

	// fixed widths of the item fields
	localparam int OP_W     = 3;
	localparam int SLOT_F_W = 5;
	localparam int FIELD_W  = 16;
	localparam int KIND_W   = 3;

	typedef enum logic [OP_W-1:0] {
		OP_TICK   = 3'd0,
		OP_CREATE = 3'd1,
		OP_DELETE = 3'd2,
		OP_START  = 3'd3,
		OP_STOP   = 3'd4,
		OP_CLEAR  = 3'd5
	} op_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_FIRED   = 3'd0,
		KIND_CREATED = 3'd1,
		KIND_FULL    = 3'd2,
		KIND_DELETED = 3'd3,
		KIND_REFUSED = 3'd4
	} kind_t;

	// what the tick unit decides for one slot
	typedef struct packed {
		logic wr;
		logic fire;
		logic free_slot;
	} slot_upd_t;

endpackage

[hdl/msst_store.sv]
module msst_store import msst_pkg::*; #(
	parameter int SLOTS      = DEF_SLOTS,
	parameter int COUNT_BITS = DEF_COUNT_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     rd_en,
	input  logic [$clog2(SLOTS)-1:0] rd_addr,
	output logic [COUNT_BITS-1:0]    rd_cd,
	output logic [COUNT_BITS-1:0]    rd_rp,
	output logic [COUNT_BITS-1:0]    rd_rl,
	input  logic                     wr_cr,
	input  logic                     wr_rl,
	input  logic [$clog2(SLOTS)-1:0] wr_addr,
	input  logic [COUNT_BITS-1:0]    wr_cd,
	input  logic [COUNT_BITS-1:0]    wr_rp,
	input  logic [COUNT_BITS-1:0]    wr_rl_data
);

	localparam int WORD_W = 2 * COUNT_BITS;

	// countdown and repeats share one word, reload sits apart
	logic [WORD_W-1:0]     cr_mem [SLOTS];
	logic [COUNT_BITS-1:0] rl_mem [SLOTS];
	logic [WORD_W-1:0]     cr_rd_q;
	logic [COUNT_BITS-1:0] rl_rd_q;
	logic [SLOTS-1:0]      cr_vld_q;
	logic [SLOTS-1:0]      rl_vld_q;
	logic                  cr_ok_q;
	logic                  rl_ok_q;

	always_ff @(posedge clk) begin
		if (wr_cr) begin
			cr_mem[wr_addr] <= {wr_cd, wr_rp};
		end
		if (wr_rl) begin
			rl_mem[wr_addr] <= wr_rl_data;
		end
		if (rd_en) begin
			cr_rd_q <= cr_mem[rd_addr];
			rl_rd_q <= rl_mem[rd_addr];
		end
	end

	// entries never written read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cr_vld_q <= '0;
			rl_vld_q <= '0;
			cr_ok_q  <= 1'b0;
			rl_ok_q  <= 1'b0;
		end else begin
			if (wr_cr) begin
				cr_vld_q[wr_addr] <= 1'b1;
			end
			if (wr_rl) begin
				rl_vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				cr_ok_q <= cr_vld_q[rd_addr];
				rl_ok_q <= rl_vld_q[rd_addr];
			end
		end
	end

	assign rd_cd = cr_ok_q ? cr_rd_q[WORD_W-1:COUNT_BITS] : '0;
	assign rd_rp = cr_ok_q ? cr_rd_q[COUNT_BITS-1:0] : '0;
	assign rd_rl = rl_ok_q ? rl_rd_q : '0;

endmodule

[hdl/msst_slot_unit.sv]
module msst_slot_unit import msst_pkg::*; #(
	parameter int COUNT_BITS = DEF_COUNT_BITS
) (
	input  logic [COUNT_BITS-1:0] cd,
	input  logic [COUNT_BITS-1:0] rp,
	input  logic [COUNT_BITS-1:0] rl,
	input  logic                  active,
	output slot_upd_t             upd,
	output logic [COUNT_BITS-1:0] cd_nxt,
	output logic [COUNT_BITS-1:0] rp_nxt
);

	localparam logic [COUNT_BITS-1:0] ONE = COUNT_BITS'(1);

	logic cd_zero;
	logic rp_zero;
	logic rp_one;

	assign cd_zero = (cd == '0);
	assign rp_zero = (rp == '0);
	assign rp_one  = (rp == ONE);

	always_comb begin
		upd    = '0;
		cd_nxt = cd;
		rp_nxt = rp;
		if (!cd_zero) begin
			// counts down even when stopped or free
			upd.wr = 1'b1;
			cd_nxt = cd - ONE;
		end else if (active) begin
			upd.wr   = 1'b1;
			upd.fire = 1'b1;
			if (rp_zero) begin
				cd_nxt = rl;
			end else if (rp_one) begin
				upd.free_slot = 1'b1;
				cd_nxt        = '0;
				rp_nxt        = '0;
			end else begin
				cd_nxt = rl;
				rp_nxt = rp - ONE;
			end
		end
	end

endmodule

[hdl/multi_slot_software_timer_table.sv]
// channel  | handshake          | payload
// ---------+--------------------+-------------------------------------------------
// input    | in_valid/in_ready  | operation, slot, delay_ticks, repeat_count,
//          |                    | start_running
// output   | out_valid/out_ready| kind, slot_number, last
//
// tick: one slot per cycle through the shared count unit and the one-read,
// one-write slot store, while no fire waits on a stalled output.
// create scans for the lowest free slot. start, stop and clear are handled
// in idle itself and never leave it.
// reset clears the flags and the store's entry valid bits, no clearing pass.
// in_ready is high only in idle; one output register lets an item enter while
// the previous result waits.
module multi_slot_software_timer_table import msst_pkg::*; #(
	parameter int SLOTS      = DEF_SLOTS,
	parameter int COUNT_BITS = DEF_COUNT_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [OP_W-1:0]     operation,
	input  logic [SLOT_F_W-1:0] slot,
	input  logic [FIELD_W-1:0]  delay_ticks,
	input  logic [FIELD_W-1:0]  repeat_count,
	input  logic                start_running,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [KIND_W-1:0]   kind,
	output logic [SLOT_F_W-1:0] slot_number,
	output logic                last
);

	localparam int SLOT_W = $clog2(SLOTS);
	localparam int PTR_W  = $clog2(SLOTS + 1);
	localparam logic [PTR_W-1:0] SLOTS_P = PTR_W'(SLOTS);

	typedef enum logic [2:0] {
		S_IDLE,
		S_TICK,
		S_TEND,
		S_CREATE,
		S_DEL,
		S_EMIT
	} state_t;

	state_t                state_q;
	logic [PTR_W-1:0]      ptr_q;
	logic                  ev_valid_s1;
	logic [SLOT_W-1:0]     ev_slot_s1;
	logic                  pend_valid_q;
	logic [SLOT_W-1:0]     pend_slot_q;
	kind_t                 res_kind_q;
	logic [SLOT_F_W-1:0]   res_slot_q;
	logic                  out_valid_q;
	kind_t                 kind_q;
	logic [SLOT_F_W-1:0]   slot_number_q;
	logic                  last_q;
	logic [SLOTS-1:0]      in_use_q;
	logic [SLOTS-1:0]      running_q;
	logic [SLOT_F_W-1:0]   slot_q;
	logic [COUNT_BITS-1:0] delay_q;
	logic [COUNT_BITS-1:0] reps_q;
	logic                  run_q;

	logic                  out_busy;
	logic [SLOT_W-1:0]     ptr_idx;
	logic                  tick_stall;
	logic                  rd_en;
	logic                  slot_ok;
	logic [SLOT_W-1:0]     slot_idx;
	logic                  in_slot_ok;
	logic [SLOT_W-1:0]     in_slot_idx;
	logic                  del_hit;
	logic                  wr_cr;
	logic                  wr_rl;
	logic [SLOT_W-1:0]     wr_addr;
	logic [COUNT_BITS-1:0] wr_cd;
	logic [COUNT_BITS-1:0] wr_rp;
	logic [COUNT_BITS-1:0] wr_rl_data;
	logic [COUNT_BITS-1:0] rd_cd;
	logic [COUNT_BITS-1:0] rd_rp;
	logic [COUNT_BITS-1:0] rd_rl;
	slot_upd_t             upd;
	logic [COUNT_BITS-1:0] cd_nxt;
	logic [COUNT_BITS-1:0] rp_nxt;

	msst_store #(
		.SLOTS      (SLOTS),
		.COUNT_BITS (COUNT_BITS)
	) u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.rd_en      (rd_en),
		.rd_addr    (ptr_idx),
		.rd_cd      (rd_cd),
		.rd_rp      (rd_rp),
		.rd_rl      (rd_rl),
		.wr_cr      (wr_cr),
		.wr_rl      (wr_rl),
		.wr_addr    (wr_addr),
		.wr_cd      (wr_cd),
		.wr_rp      (wr_rp),
		.wr_rl_data (wr_rl_data)
	);

	msst_slot_unit #(
		.COUNT_BITS (COUNT_BITS)
	) u_slot_unit (
		.cd     (rd_cd),
		.rp     (rd_rp),
		.rl     (rd_rl),
		.active (in_use_q[ev_slot_s1] && running_q[ev_slot_s1]),
		.upd    (upd),
		.cd_nxt (cd_nxt),
		.rp_nxt (rp_nxt)
	);

	always_comb begin
		out_busy    = out_valid_q && !out_ready;
		ptr_idx     = ptr_q[SLOT_W-1:0];
		// a second fire needs the held one moved out first
		tick_stall  = ev_valid_s1 && upd.fire && pend_valid_q && out_busy;
		rd_en       = (state_q == S_TICK) && !tick_stall && (ptr_q < SLOTS_P);
		slot_ok     = int'(slot_q) < SLOTS;
		slot_idx    = SLOT_W'(slot_q);
		in_slot_ok  = int'(slot) < SLOTS;
		in_slot_idx = SLOT_W'(slot);
		del_hit     = slot_ok && in_use_q[slot_idx];

		wr_cr      = 1'b0;
		wr_rl      = 1'b0;
		wr_addr    = ev_slot_s1;
		wr_cd      = cd_nxt;
		wr_rp      = rp_nxt;
		wr_rl_data = delay_q;
		unique case (state_q)
			S_TICK: begin
				wr_cr = ev_valid_s1 && !tick_stall && upd.wr;
			end
			S_CREATE: begin
				wr_addr = ptr_idx;
				wr_cd   = delay_q;
				wr_rp   = reps_q;
				if (ptr_q < SLOTS_P && !in_use_q[ptr_idx]) begin
					wr_cr = 1'b1;
					wr_rl = 1'b1;
				end
			end
			S_DEL: begin
				wr_addr = slot_idx;
				wr_cd   = '0;
				wr_rp   = '0;
				wr_cr   = del_hit;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			ptr_q         <= '0;
			ev_valid_s1   <= 1'b0;
			ev_slot_s1    <= '0;
			pend_valid_q  <= 1'b0;
			pend_slot_q   <= '0;
			res_kind_q    <= KIND_FIRED;
			res_slot_q    <= '0;
			out_valid_q   <= 1'b0;
			kind_q        <= KIND_FIRED;
			slot_number_q <= '0;
			last_q        <= 1'b0;
			in_use_q      <= '0;
			running_q     <= '0;
			slot_q        <= '0;
			delay_q       <= '0;
			reps_q        <= '0;
			run_q         <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						slot_q  <= slot;
						delay_q <= COUNT_BITS'(delay_ticks);
						reps_q  <= COUNT_BITS'(repeat_count);
						run_q   <= start_running;
						ptr_q   <= '0;
						unique case (operation)
							OP_TICK: begin
								ev_valid_s1  <= 1'b0;
								pend_valid_q <= 1'b0;
								state_q      <= S_TICK;
							end
							OP_CREATE: state_q <= S_CREATE;
							OP_DELETE: state_q <= S_DEL;
							OP_START: begin
								if (in_slot_ok) begin
									running_q[in_slot_idx] <= 1'b1;
								end
							end
							OP_STOP: begin
								if (in_slot_ok) begin
									running_q[in_slot_idx] <= 1'b0;
								end
							end
							OP_CLEAR: in_use_q <= '0;
							default: begin
							end
						endcase
					end
				end
				S_TICK: begin
					if (!tick_stall) begin
						ev_valid_s1 <= rd_en;
						ev_slot_s1  <= ptr_idx;
						if (rd_en) begin
							ptr_q <= ptr_q + 1'b1;
						end else begin
							state_q <= S_TEND;
						end
						if (ev_valid_s1) begin
							if (upd.free_slot) begin
								in_use_q[ev_slot_s1]  <= 1'b0;
								running_q[ev_slot_s1] <= 1'b0;
							end
							// hold each fire back one so the final one can carry last
							if (upd.fire) begin
								if (pend_valid_q) begin
									out_valid_q   <= 1'b1;
									kind_q        <= KIND_FIRED;
									slot_number_q <= SLOT_F_W'(pend_slot_q);
									last_q        <= 1'b0;
								end
								pend_valid_q <= 1'b1;
								pend_slot_q  <= ev_slot_s1;
							end
						end
					end
				end
				S_TEND: begin
					if (!pend_valid_q) begin
						state_q <= S_IDLE;
					end else if (!out_busy) begin
						out_valid_q   <= 1'b1;
						kind_q        <= KIND_FIRED;
						slot_number_q <= SLOT_F_W'(pend_slot_q);
						last_q        <= 1'b1;
						pend_valid_q  <= 1'b0;
						state_q       <= S_IDLE;
					end
				end
				S_CREATE: begin
					if (ptr_q == SLOTS_P) begin
						res_kind_q <= KIND_FULL;
						res_slot_q <= '0;
						state_q    <= S_EMIT;
					end else if (!in_use_q[ptr_idx]) begin
						in_use_q[ptr_idx]  <= 1'b1;
						running_q[ptr_idx] <= run_q;
						res_kind_q         <= KIND_CREATED;
						res_slot_q         <= SLOT_F_W'(ptr_idx);
						state_q            <= S_EMIT;
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				S_DEL: begin
					if (del_hit) begin
						in_use_q[slot_idx]  <= 1'b0;
						running_q[slot_idx] <= 1'b0;
						res_kind_q          <= KIND_DELETED;
					end else begin
						res_kind_q <= KIND_REFUSED;
					end
					res_slot_q <= slot_q;
					state_q    <= S_EMIT;
				end
				S_EMIT: begin
					if (!out_busy) begin
						out_valid_q   <= 1'b1;
						kind_q        <= res_kind_q;
						slot_number_q <= res_slot_q;
						last_q        <= 1'b1;
						state_q       <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready    = (state_q == S_IDLE);
	assign out_valid   = out_valid_q;
	assign kind        = kind_q;
	assign slot_number = slot_number_q;
	assign last        = last_q;

	// a held fire never outlives its tick
	a_pend_in_tick: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> (state_q == S_TICK || state_q == S_TEND))
		else $error("held fire outside a tick");

	// store read data only counts while walking
	a_ev_in_tick: assert property (@(posedge clk) disable iff (!arst_n)
		ev_valid_s1 |-> state_q == S_TICK)
		else $error("slot evaluation outside a tick");

	// a stalled second fire must not overwrite the held one
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TICK && tick_stall) |=> ($stable(pend_slot_q) && pend_valid_q))
		else $error("held fire lost during output stall");

	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		ptr_q <= SLOTS_P)
		else $error("slot pointer past table end");

endmodule
